### hdl/chgs_pkg.sv
// Shared beat types and unit status for the Graham scan convex hull block.
package chgs_pkg;

    typedef struct packed {
        logic [11:0] x_coord;
        logic [11:0] y_coord;
        logic        last_point;
    } point_t;

    typedef struct packed {
        logic [11:0] hull_x;
        logic [11:0] hull_y;
        logic        hull_last;
        logic        overflowed;
    } vertex_t;

    // Status of the cross product unit.
    typedef struct packed {
        logic valid;
        logic pos;
        logic zero;
    } xres_t;

endpackage

### hdl/convex_hull_graham_scan.sv
// Top level: point load, angular insertion sort and Graham scan sequencer.
//
// Usage: points arrive on pt (valid/ready), one beat per point. The beat with
// last_point set closes the set and starts the hull run; points beyond
// MAX_POINTS are dropped and the run's vertices carry overflowed. Vertices
// leave on vtx (valid/ready) counterclockwise from the lowest-y point, with
// hull_last on the final one. pt_ready is high only while loading.
// Load accepts one point per cycle. After the last point, the sort inserts
// each point in angular order, paced by the order RAM read, the point read
// and the two-stage cross product unit; the scan then pushes and pops on the
// stack RAM, and each vertex is read back out through the stack RAM.
// A stalled vtx receiver holds the output register; the sequencer waits on
// it and nothing is lost. Reset empties the set and clears the output valid;
// RAM contents need no clearing since only entries written in a set are read.
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  chgs_pkg::point_t  pt,
    input  logic              pt_valid,
    output logic              pt_ready,
    output chgs_pkg::vertex_t vtx,
    output logic              vtx_valid,
    input  logic              vtx_ready
);
    import chgs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * COORD_BITS;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);

    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_MID  = 2'd1;
    localparam logic [1:0] CLS_BACK = 2'd2;

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_SNEXT = 14'b00000000000010,
        S_SGET  = 14'b00000000000100,
        S_SJ    = 14'b00000000001000,
        S_SOWT  = 14'b00000000010000,
        S_SCMP  = 14'b00000000100000,
        S_SCANI = 14'b00000001000000,
        S_KNEXT = 14'b00000010000000,
        S_KGET  = 14'b00000100000000,
        S_TEST  = 14'b00001000000000,
        S_TWT   = 14'b00010000000000,
        S_POPWT = 14'b00100000000000,
        S_ERD   = 14'b01000000000000,
        S_ELD   = 14'b10000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] piv_slot_reg, piv_slot_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic          fin_reg, fin_next;
    logic          ov_reg, ov_next;

    logic [CB-1:0] piv_x_reg, piv_x_next, piv_y_reg, piv_y_next;
    logic [CB-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CB-1:0] cmp_x_reg, cmp_x_next, cmp_y_reg, cmp_y_next;
    logic [CB-1:0] top_x_reg, top_x_next, top_y_reg, top_y_next;
    logic [CB-1:0] sec_x_reg, sec_x_next, sec_y_reg, sec_y_next;
    vertex_t       vtx_reg, vtx_next;

    // memory ports
    logic          st_we, st_re, od_we, od_re, sk_we, sk_re;
    logic [IW-1:0] st_waddr, st_raddr, od_waddr, od_raddr, sk_waddr, sk_raddr;
    logic [PW-1:0] st_wdata, st_rdata, od_wdata, od_rdata, sk_wdata, sk_rdata;

    // cross unit
    logic          x_start;
    logic [CB-1:0] x_ox, x_oy, x_ax, x_ay, x_bx, x_by;
    xres_t         x_res;

    logic [CB-1:0] in_x, in_y;
    logic [1:0]    cls_a, cls_b;
    logic          cur_first;
    logic          pt_acc;

    assign in_x     = CB'(pt.x_coord);
    assign in_y     = CB'(pt.y_coord);
    assign pt_ready = (state_reg == S_LOAD);
    assign pt_acc   = pt_valid && pt_ready;
    assign vtx      = vtx_reg;
    assign vtx_valid = ov_reg;

    chgs_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
    );

    chgs_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_order (
        .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
        .re(od_re), .raddr(od_raddr), .rdata(od_rdata)
    );

    chgs_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_stack (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .re(sk_re), .raddr(sk_raddr), .rdata(sk_rdata)
    );

    chgs_cross #(.CB(CB)) u_cross (
        .clk(clk), .rst_n(rst_n), .start(x_start),
        .ox(x_ox), .oy(x_oy), .ax(x_ax), .ay(x_ay), .bx(x_bx), .by(x_by),
        .res(x_res)
    );

    // angle class about the pivot: zero angle, strictly between, or 180
    always_comb
    begin
        if (cur_y_reg != piv_y_reg)
            cls_a = CLS_MID;
        else if (cur_x_reg >= piv_x_reg)
            cls_a = CLS_ZERO;
        else
            cls_a = CLS_BACK;
        if (cmp_y_reg != piv_y_reg)
            cls_b = CLS_MID;
        else if (cmp_x_reg >= piv_x_reg)
            cls_b = CLS_ZERO;
        else
            cls_b = CLS_BACK;

        // same ray: nearer first, measured along the ray's own axis
        if (cls_a != cls_b)
            cur_first = cls_a < cls_b;
        else if (cls_a == CLS_MID)
            cur_first = x_res.zero ? (cur_y_reg < cmp_y_reg) : x_res.pos;
        else if (cls_a == CLS_ZERO)
            cur_first = cur_x_reg < cmp_x_reg;
        else
            cur_first = cur_x_reg > cmp_x_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        piv_slot_next = piv_slot_reg;
        drop_next     = drop_reg;
        s_next        = s_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        depth_next    = depth_reg;
        fin_next      = fin_reg;
        ov_next       = ov_reg && !vtx_ready;
        piv_x_next    = piv_x_reg;
        piv_y_next    = piv_y_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cmp_x_next    = cmp_x_reg;
        cmp_y_next    = cmp_y_reg;
        top_x_next    = top_x_reg;
        top_y_next    = top_y_reg;
        sec_x_next    = sec_x_reg;
        sec_y_next    = sec_y_reg;
        vtx_next      = vtx_reg;

        st_we = 1'b0; st_waddr = cnt_reg[IW-1:0]; st_wdata = {in_x, in_y};
        st_re = 1'b0; st_raddr = s_reg[IW-1:0];
        od_we = 1'b0; od_waddr = j_reg[IW-1:0];   od_wdata = {cur_x_reg, cur_y_reg};
        od_re = 1'b0; od_raddr = j_reg[IW-1:0] - IW'(1);
        sk_we = 1'b0; sk_waddr = depth_reg[IW-1:0]; sk_wdata = {cur_x_reg, cur_y_reg};
        sk_re = 1'b0; sk_raddr = k_reg[IW-1:0];

        x_start = 1'b0;
        x_ox = piv_x_reg; x_oy = piv_y_reg;
        x_ax = cur_x_reg; x_ay = cur_y_reg;
        x_bx = od_rdata[PW-1:CB]; x_by = od_rdata[CB-1:0];

        unique case (state_reg)
            S_LOAD:
            begin
                if (pt_acc)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                    begin
                        st_we    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                        if (cnt_reg == '0 || in_y < piv_y_reg)
                        begin
                            piv_slot_next = cnt_reg[IW-1:0];
                            piv_x_next    = in_x;
                            piv_y_next    = in_y;
                        end
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (pt.last_point)
                    begin
                        s_next     = '0;
                        n_next     = '0;
                        state_next = S_SNEXT;
                    end
                end
            end
            S_SNEXT:
            begin
                if (s_reg == cnt_reg)
                    state_next = S_SCANI;
                else if (s_reg == CW'(piv_slot_reg))
                    s_next = s_reg + CW'(1);
                else
                begin
                    st_re      = 1'b1;
                    state_next = S_SGET;
                end
            end
            S_SGET:
            begin
                cur_x_next = st_rdata[PW-1:CB];
                cur_y_next = st_rdata[CB-1:0];
                j_next     = n_reg;
                state_next = S_SJ;
            end
            S_SJ:
            begin
                if (j_reg == '0)
                begin
                    od_we      = 1'b1;
                    n_next     = n_reg + CW'(1);
                    s_next     = s_reg + CW'(1);
                    state_next = S_SNEXT;
                end
                else
                begin
                    od_re      = 1'b1;
                    state_next = S_SOWT;
                end
            end
            S_SOWT:
            begin
                cmp_x_next = od_rdata[PW-1:CB];
                cmp_y_next = od_rdata[CB-1:0];
                x_start    = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (x_res.valid)
                begin
                    od_we = 1'b1;
                    if (cur_first)
                    begin
                        od_wdata = {cmp_x_reg, cmp_y_reg};
                        j_next   = j_reg - CW'(1);
                        state_next = S_SJ;
                    end
                    else
                    begin
                        n_next     = n_reg + CW'(1);
                        s_next     = s_reg + CW'(1);
                        state_next = S_SNEXT;
                    end
                end
            end
            S_SCANI:
            begin
                sk_we      = 1'b1;
                sk_waddr   = '0;
                sk_wdata   = {piv_x_reg, piv_y_reg};
                top_x_next = piv_x_reg;
                top_y_next = piv_y_reg;
                depth_next = CW'(1);
                k_next     = '0;
                fin_next   = 1'b0;
                state_next = S_KNEXT;
            end
            S_KNEXT:
            begin
                if (k_reg == n_reg)
                begin
                    cur_x_next = piv_x_reg;
                    cur_y_next = piv_y_reg;
                    fin_next   = 1'b1;
                    state_next = S_TEST;
                end
                else
                begin
                    od_re      = 1'b1;
                    od_raddr   = k_reg[IW-1:0];
                    state_next = S_KGET;
                end
            end
            S_KGET:
            begin
                cur_x_next = od_rdata[PW-1:CB];
                cur_y_next = od_rdata[CB-1:0];
                state_next = S_TEST;
            end
            S_TEST, S_TWT:
            begin
                x_ox = sec_x_reg; x_oy = sec_y_reg;
                x_ax = top_x_reg; x_ay = top_y_reg;
                x_bx = cur_x_reg; x_by = cur_y_reg;
                if (state_reg == S_TEST && depth_reg >= CW'(2))
                begin
                    x_start    = 1'b1;
                    state_next = S_TWT;
                end
                else if (state_reg == S_TWT && !x_res.valid)
                begin
                    state_next = S_TWT;
                end
                else if (state_reg == S_TWT && !x_res.pos)
                begin
                    // not a strict left turn: drop the top
                    depth_next = depth_reg - CW'(1);
                    top_x_next = sec_x_reg;
                    top_y_next = sec_y_reg;
                    if (depth_reg >= CW'(3))
                    begin
                        sk_re      = 1'b1;
                        sk_raddr   = depth_reg[IW-1:0] - IW'(3);
                        state_next = S_POPWT;
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
                else if (fin_reg)
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    sk_we      = 1'b1;
                    sec_x_next = top_x_reg;
                    sec_y_next = top_y_reg;
                    top_x_next = cur_x_reg;
                    top_y_next = cur_y_reg;
                    depth_next = depth_reg + CW'(1);
                    k_next     = k_reg + CW'(1);
                    state_next = S_KNEXT;
                end
            end
            S_POPWT:
            begin
                sec_x_next = sk_rdata[PW-1:CB];
                sec_y_next = sk_rdata[CB-1:0];
                state_next = S_TEST;
            end
            S_ERD:
            begin
                sk_re      = 1'b1;
                state_next = S_ELD;
            end
            S_ELD:
            begin
                if (!ov_reg || vtx_ready)
                begin
                    ov_next             = 1'b1;
                    vtx_next.hull_x     = 12'(sk_rdata[PW-1:CB]);
                    vtx_next.hull_y     = 12'(sk_rdata[CB-1:0]);
                    vtx_next.hull_last  = (k_reg + CW'(1) == depth_reg);
                    vtx_next.overflowed = drop_reg;
                    k_next              = k_reg + CW'(1);
                    if (k_reg + CW'(1) == depth_reg)
                    begin
                        cnt_next      = '0;
                        piv_slot_next = '0;
                        drop_next     = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            piv_slot_reg <= '0;
            drop_reg     <= 1'b0;
            s_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            k_reg        <= '0;
            depth_reg    <= '0;
            fin_reg      <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            piv_slot_reg <= piv_slot_next;
            drop_reg     <= drop_next;
            s_reg        <= s_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            depth_reg    <= depth_next;
            fin_reg      <= fin_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_x_reg <= piv_x_next;
        piv_y_reg <= piv_y_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        cmp_x_reg <= cmp_x_next;
        cmp_y_reg <= cmp_y_next;
        top_x_reg <= top_x_next;
        top_y_reg <= top_y_next;
        sec_x_reg <= sec_x_next;
        sec_y_reg <= sec_y_next;
        vtx_reg   <= vtx_next;
    end

    // cross results only land while the sequencer waits for them
    a_xres_wait: assert property (@(posedge clk) disable iff (!rst_n)
        x_res.valid |-> (state_reg == S_SCMP || state_reg == S_TWT))
        else $error("cross result outside a wait state");

    a_sort_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCMP) |-> (j_reg != '0 && j_reg <= n_reg && n_reg < cnt_reg))
        else $error("sort index out of range");

    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ELD) |-> (depth_reg != '0 && k_reg < depth_reg))
        else $error("emit index beyond stack depth");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_acc && pt.last_point) |=> (state_reg == S_SNEXT && cnt_reg != '0))
        else $error("run started with an empty set");

endmodule

### hdl/chgs_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module chgs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/chgs_cross.sv
// Two-stage cross product unit: sign of (a - o) x (b - o).
module chgs_cross #(
    parameter int CB = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [CB-1:0]   ox,
    input  logic [CB-1:0]   oy,
    input  logic [CB-1:0]   ax,
    input  logic [CB-1:0]   ay,
    input  logic [CB-1:0]   bx,
    input  logic [CB-1:0]   by,
    output chgs_pkg::xres_t res
);
    import chgs_pkg::*;

    logic signed [CB:0]     dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [2*CB+1:0] p1_reg, p2_reg;
    logic                   v1_reg, v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dax_reg <= $signed({1'b0, ax}) - $signed({1'b0, ox});
        day_reg <= $signed({1'b0, ay}) - $signed({1'b0, oy});
        dbx_reg <= $signed({1'b0, bx}) - $signed({1'b0, ox});
        dby_reg <= $signed({1'b0, by}) - $signed({1'b0, oy});
        p1_reg  <= dax_reg * dby_reg;
        p2_reg  <= day_reg * dbx_reg;
    end

    assign res.valid = v2_reg;
    assign res.pos   = p1_reg > p2_reg;
    assign res.zero  = p1_reg == p2_reg;

endmodule
